[sv/mhpq_pkg.sv]
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 8;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = 32'sh7FFF_FFFF;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_SEL,
    S_DN_CMP
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key_in;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    status_e                 status;
    logic [COUNT_W-1:0]      count;
  } out_t;

  // Completion report from the sequencer to the result register.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    status_e                 status;
  } done_t;

endpackage

`default_nettype wire

[sv/mhpq_ram.sv]
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/mhpq_ctrl.sv]
`default_nettype none

module mhpq_ctrl #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
  localparam int IDX_W   = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire mhpq_pkg::in_t         in_i,
  output logic                       busy_o,
  output logic [CNT_W-1:0]           cnt_o,
  output mhpq_pkg::done_t            done_o,
  output logic                       we_o,
  output logic [IDX_W-1:0]           waddr_o,
  output logic [mhpq_pkg::KEY_W-1:0] wdata_o,
  output logic [IDX_W-1:0]           raddr_o,
  input  wire logic [mhpq_pkg::KEY_W-1:0] rdata_i
);

  import mhpq_pkg::*;

  localparam int CW = CNT_W + 1;

  state_e state_q, state_d;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [IDX_W-1:0]        cidx_q, cidx_d;
  logic signed [KEY_W-1:0] k_q, k_d;
  logic signed [KEY_W-1:0] c_q, c_d;
  logic signed [KEY_W-1:0] out_q, out_d;
  logic                    has_r_q, has_r_d;

  logic signed [KEY_W-1:0] rdata;
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    lt;
  logic [CW-1:0]           left, right, cntx;
  logic [IDX_W-1:0]        parent;
  logic                    full, empty;

  assign rdata  = $signed(rdata_i);
  assign left   = CW'({pos_q, 1'b1});
  assign right  = left + CW'(1);
  assign cntx   = CW'(cnt_q);
  assign parent = IDX_W'((pos_q - IDX_W'(1)) >> 1);
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign empty  = (cnt_q == '0);

  // The single key comparator, shared by the compare steps of both sift directions.
  always_comb begin
    case (state_q)
      S_UP_CMP: begin
        cmp_a = k_q;
        cmp_b = rdata;
      end
      S_DN_SEL: begin
        cmp_a = rdata;
        cmp_b = c_q;
      end
      default: begin
        cmp_a = c_q;
        cmp_b = k_q;
      end
    endcase
  end

  assign lt = (cmp_a < cmp_b);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (in_i.op == OP_INSERT && !full) begin
            state_d = S_UP_RD;
          end else if (in_i.op == OP_EXTRACT && !empty) begin
            state_d = S_DN_ROOT;
          end
        end
      end
      S_UP_RD:   state_d = (pos_q == '0) ? S_IDLE : S_UP_CMP;
      S_UP_CMP:  state_d = lt ? S_UP_RD : S_IDLE;
      S_DN_ROOT: state_d = empty ? S_IDLE : S_DN_LAST;
      S_DN_LAST: state_d = S_DN_RDL;
      S_DN_RDL:  state_d = (left >= cntx) ? S_IDLE : S_DN_RDR;
      S_DN_RDR:  state_d = S_DN_SEL;
      S_DN_SEL:  state_d = S_DN_CMP;
      S_DN_CMP:  state_d = lt ? S_DN_RDL : S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    cidx_d  = cidx_q;
    k_d     = k_q;
    c_d     = c_q;
    out_d   = out_q;
    has_r_d = has_r_q;
    we_o    = 1'b0;
    waddr_o = pos_q;
    wdata_o = k_q;
    raddr_o = '0;
    done_o  = '{valid: 1'b0, key: '0, status: STAT_OK};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (in_i.op == OP_INSERT) begin
            if (full) begin
              done_o = '{valid: 1'b1, key: '0, status: STAT_FULL};
            end else begin
              pos_d = IDX_W'(cnt_q);
              cnt_d = cnt_q + CNT_W'(1);
              k_d   = in_i.key_in;
            end
          end else begin
            if (empty) begin
              done_o = '{valid: 1'b1, key: EMPTY_KEY, status: STAT_EMPTY};
            end else begin
              // Root read goes out now; its data arrives in the next state.
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          we_o   = 1'b1;
          done_o = '{valid: 1'b1, key: '0, status: STAT_OK};
        end else begin
          raddr_o = parent;
        end
      end
      S_UP_CMP: begin
        we_o = 1'b1;
        if (lt) begin
          // Parent moves down into the hole; the new key travels in k_q.
          wdata_o = rdata;
          pos_d   = parent;
        end else begin
          done_o = '{valid: 1'b1, key: '0, status: STAT_OK};
        end
      end
      S_DN_ROOT: begin
        out_d   = rdata;
        pos_d   = '0;
        raddr_o = IDX_W'(cnt_q);
        if (empty) begin
          done_o = '{valid: 1'b1, key: rdata, status: STAT_OK};
        end
      end
      S_DN_LAST: begin
        k_d = rdata;
      end
      S_DN_RDL: begin
        if (left >= cntx) begin
          we_o   = 1'b1;
          done_o = '{valid: 1'b1, key: out_q, status: STAT_OK};
        end else begin
          raddr_o = IDX_W'(left);
        end
      end
      S_DN_RDR: begin
        c_d     = rdata;
        cidx_d  = IDX_W'(left);
        raddr_o = IDX_W'(right);
        has_r_d = (right < cntx);
      end
      S_DN_SEL: begin
        // The right child wins only when it exists and is strictly smaller.
        if (has_r_q && lt) begin
          c_d    = rdata;
          cidx_d = IDX_W'(right);
        end
      end
      S_DN_CMP: begin
        we_o = 1'b1;
        if (lt) begin
          wdata_o = c_q;
          pos_d   = cidx_q;
        end else begin
          done_o = '{valid: 1'b1, key: out_q, status: STAT_OK};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cidx_q  <= cidx_d;
    k_q     <= k_d;
    c_q     <= c_d;
    out_q   <= out_d;
    has_r_q <= has_r_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign cnt_o  = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> state_q != S_IDLE)
    else $error("heap write while idle");

  a_immediate_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o.valid && state_q == S_IDLE) |-> done_o.status != STAT_OK)
    else $error("ok status reported without sifting");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UP_CMP |-> pos_q != '0)
    else $error("sift-up compare at the root");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(cnt_q))
    else $error("entry count changed during a sift");

endmodule

`default_nettype wire

[sv/min_heap_priority_queue.sv]
`default_nettype none

// Binary min-heap priority queue of signed 32-bit keys.
// A word is accepted on a rising edge with start_i high and busy_o low. Its op
// field selects insert of key_in or extract of the smallest key held.
// Every accepted word yields exactly one result word on res_o, marked by
// done_o for a single cycle; the receiver must take it then, it cannot stall.
// The result carries the extracted key (0 on insert, 0x7FFFFFFF when empty),
// a status (ok, extract from empty, insert into full dropped) and the number
// of keys held afterwards, reduced to 8 bits.
// Keys live in a single-port-read, single-port-write RAM with registered
// read, walked by a sequencer around one shared key comparator.
// Insert: per level climbed, the parent is read and compared; the key is written
// when it reaches the root or when the compare stops the climb.
// Extract: with a single key held it ends after the root read; otherwise the last
// key is read, then per level both children are read, the smaller is selected and
// compared, and the key is written at a leaf or when the compare stops the walk.
// Empty or full cases finish in the accept cycle. done_o rises at the edge at
// which busy_o falls, in the cycle in which the next word may be accepted.
// Reset empties the queue at once; no clearing pass is needed.
module min_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire mhpq_pkg::in_t  in_i,
  output logic                busy_o,
  output logic                done_o,
  output mhpq_pkg::out_t      res_o
);

  import mhpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt;
  done_t            done;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [KEY_W-1:0] wdata, rdata;

  logic done_q;
  out_t res_q;

  mhpq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .cnt_o  (cnt),
    .done_o (done),
    .we_o   (we),
    .waddr_o(waddr),
    .wdata_o(wdata),
    .raddr_o(raddr),
    .rdata_i(rdata)
  );

  mhpq_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid) begin
      res_q.key_out <= done.key;
      res_q.status  <= done.status;
      res_q.count   <= COUNT_W'(cnt);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
